// ----- hdl/svs_pkg.sv -----
// svs_pkg: types, constants and helper functions of the step-up voltage sequencer.
// Used by svs_convert, svs_sequencer and stepup_voltage_sequencer; no dependencies.
package svs_pkg;

  // Field widths
  localparam int AdcW     = 12;
  localparam int MvW      = 16;
  localparam int CodeW    = 5;
  localparam int ScaledW  = 22;   // adc * 880 fits 22 bits
  localparam int InDataW  = 32;   // adc_sample + request_mv, padded to bytes
  localparam int OutDataW = 32;   // 25 bits of result, padded to bytes

  // Request window and code mapping: code = floor((mv - 1200) / 750)
  localparam logic [MvW-1:0]   ReqMinMv   = 16'd4000;
  localparam logic [MvW-1:0]   ReqMaxMv   = 16'd26000;
  localparam logic [MvW-1:0]   CodeBaseMv = 16'd1200;
  localparam logic [CodeW-1:0] CodeMax    = 5'd31;

  // floor(d / 750) = (d * 22370) >> 24 for d below 2^15
  localparam int               ReqDiffW   = 15;
  localparam int               ReqRecipW  = 15;
  localparam logic [ReqRecipW-1:0] ReqRecip = 15'd22370;
  localparam int               ReqShift   = 24;
  localparam int               ReqProdW   = ReqDiffW + ReqRecipW;

  // measured = floor(adc * 39600 / 4095) = floor(adc * 880 / 91)
  //          = (adc * 162241210) >> 24 for adc below 2^12
  localparam int               MeasRecipW = 28;
  localparam logic [MeasRecipW-1:0] MeasRecip = 28'd162241210;
  localparam int               MeasShift  = 24;
  localparam int               MeasProdW  = AdcW + MeasRecipW;

  // Drop threshold, both sides of adc*39600 < (1200+750*code)*4095 over 45
  localparam logic [ScaledW-1:0] ThreshBase = 22'd109200;
  localparam logic [ScaledW-1:0] ThreshStep = 22'd68250;

  typedef enum logic [1:0] {
    PH_OFF  = 2'd0,
    PH_IDLE = 2'd1,
    PH_WAIT = 2'd2
  } phase_t;

  // Input item after conversion, held in the input register
  typedef struct packed {
    logic               action;       // 1 = voltage request
    logic               in_range;     // request inside the window
    logic [CodeW-1:0]   req_code;     // clamped code of the request
    logic [ScaledW-1:0] adc_scaled;   // adc_sample * 880
    logic [MvW-1:0]     measured_mv;  // measured output voltage
  } item_t;

  // Result item, held in the output register
  typedef struct packed {
    logic [MvW-1:0]   measured_mv;
    logic [1:0]       phase;
    logic             power_enable;
    logic [CodeW-1:0] select_pins;
    logic             accepted;
  } result_t;

  // Scaled output level that the converter must fall below for a code
  function automatic logic [ScaledW-1:0] drop_threshold(input logic [CodeW-1:0] code);
    logic [ScaledW-1:0] step;
    step = ThreshStep * ScaledW'(code);
    return ThreshBase + step;
  endfunction

endpackage

// ----- hdl/svs_convert.sv -----
// svs_convert: constant-scaled conversions of one input item (request code,
// scaled ADC value, measured millivolts). Depends on svs_pkg.
module svs_convert (
  input  logic                       action,
  input  logic [svs_pkg::AdcW-1:0]   adc_sample,
  input  logic [svs_pkg::MvW-1:0]    request_mv,
  output svs_pkg::item_t             item
);

  logic [svs_pkg::MvW-1:0]      req_diff;
  logic [svs_pkg::ReqProdW-1:0] req_prod;
  logic [5:0]                   req_quot;
  logic [svs_pkg::MeasProdW-1:0] meas_prod;
  logic [svs_pkg::ScaledW-1:0]  adc_ext;

  // Map the request to a code by reciprocal multiply, then clamp
  assign req_diff = request_mv - svs_pkg::CodeBaseMv;
  assign req_prod = svs_pkg::ReqProdW'(req_diff[svs_pkg::ReqDiffW-1:0])
                  * svs_pkg::ReqProdW'(svs_pkg::ReqRecip);
  assign req_quot = req_prod[svs_pkg::ReqShift +: 6];

  // Scale the sample by 880 = 1024 - 128 - 16 with shifts
  assign adc_ext = svs_pkg::ScaledW'(adc_sample);

  // Convert the sample to millivolts by reciprocal multiply
  assign meas_prod = svs_pkg::MeasProdW'(adc_sample) * svs_pkg::MeasProdW'(svs_pkg::MeasRecip);

  // Assemble the converted item
  always_comb begin
    item.action   = action;
    item.in_range = (request_mv >= svs_pkg::ReqMinMv) && (request_mv <= svs_pkg::ReqMaxMv);
    if (req_quot > 6'(svs_pkg::CodeMax)) begin
      item.req_code = svs_pkg::CodeMax;
    end else begin
      item.req_code = req_quot[svs_pkg::CodeW-1:0];
    end
    item.adc_scaled  = (adc_ext << 10) - (adc_ext << 7) - (adc_ext << 4);
    item.measured_mv = meas_prod[svs_pkg::MeasShift +: svs_pkg::MvW];
  end

endmodule

// ----- hdl/svs_sequencer.sv -----
// svs_sequencer: phase machine and converter state; forms the result of the
// item in the input register. Depends on svs_pkg.
module svs_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,     // item leaves the input register
  input  svs_pkg::item_t   item,
  output svs_pkg::result_t result
);

  svs_pkg::phase_t               phase, phase_next;
  logic [svs_pkg::CodeW-1:0]     requested_code, requested_code_next;
  logic [svs_pkg::CodeW-1:0]     applied_code, applied_code_next;
  logic [svs_pkg::CodeW-1:0]     pin_code, pin_code_next;
  logic                          power_on, power_on_next;
  logic                          drive_en;
  logic [svs_pkg::CodeW-1:0]     drive_code;
  logic                          dropped;
  logic                          is_tick;

  assign is_tick = !item.action;
  assign dropped = item.adc_scaled < svs_pkg::drop_threshold(requested_code);

  // Next phase on a tick
  always_comb begin
    phase_next = phase;
    if (is_tick) begin
      unique case (phase)
        svs_pkg::PH_IDLE: begin
          if (requested_code == '0) begin
            phase_next = svs_pkg::PH_OFF;
          end else if (requested_code != applied_code) begin
            phase_next = svs_pkg::PH_WAIT;
          end
        end
        svs_pkg::PH_WAIT: begin
          if (dropped) begin
            phase_next = svs_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_next = (requested_code != '0) ? svs_pkg::PH_WAIT : svs_pkg::PH_OFF;
        end
      endcase
    end
  end

  // Converter drive decisions on a tick
  always_comb begin
    drive_en   = 1'b0;
    drive_code = '0;
    if (is_tick) begin
      unique case (phase)
        svs_pkg::PH_IDLE: begin
          drive_en = (requested_code == '0) || (requested_code != applied_code);
        end
        svs_pkg::PH_WAIT: begin
          drive_en   = dropped;
          drive_code = requested_code;
        end
        default: begin
          drive_en = 1'b0;
        end
      endcase
    end
  end

  // Apply a drive: zero only switches power off, pins keep their code
  always_comb begin
    applied_code_next = applied_code;
    pin_code_next     = pin_code;
    power_on_next     = power_on;
    if (drive_en) begin
      applied_code_next = drive_code;
      if (drive_code == '0) begin
        power_on_next = 1'b0;
      end else begin
        pin_code_next = drive_code;
        power_on_next = 1'b1;
      end
    end
  end

  // Store an in-range request
  always_comb begin
    requested_code_next = requested_code;
    if (item.action && item.in_range) begin
      requested_code_next = item.req_code;
    end
  end

  // Result shows the state after this item
  always_comb begin
    result.accepted     = is_tick || item.in_range;
    result.select_pins  = pin_code_next;
    result.power_enable = power_on_next;
    result.phase        = phase_next;
    result.measured_mv  = is_tick ? item.measured_mv : '0;
  end

  // Advance the state when the item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= svs_pkg::PH_OFF;
      requested_code <= '0;
      applied_code   <= '0;
      pin_code       <= '0;
      power_on       <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      requested_code <= requested_code_next;
      applied_code   <= applied_code_next;
      pin_code       <= pin_code_next;
      power_on       <= power_on_next;
    end
  end

endmodule

// ----- hdl/stepup_voltage_sequencer.sv -----
// stepup_voltage_sequencer: top level with input and result registers around
// the conversion and sequencing logic. Depends on svs_pkg, svs_convert, svs_sequencer.
//
//  channel | direction | payload
//  --------+-----------+---------------------------------------------------
//  s_*     | in        | tuser: action; tdata: adc_sample, request_mv
//  m_*     | out       | tdata: accepted, select_pins, power_enable, phase,
//          |           |        measured_mv
//
// One result item per input item. m_tvalid rises once the item has passed the input
// register and then the result register; an item waits in the input register while
// the result register is occupied. A new item can be taken every cycle while m_tready
// is high; the sustained rate is then one item per cycle.
// rst clears the phase to off, all codes to zero and both registers to empty.
// A stall on m_tready holds the result; the input register keeps accepting
// until it too is occupied.
module stepup_voltage_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [svs_pkg::InDataW-1:0]   s_tdata,   // [11:0] adc_sample, [27:12] request_mv
  input  logic                          s_tuser,   // [0] action
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [svs_pkg::OutDataW-1:0]  m_tdata    // [0] accepted, [5:1] select_pins,
                                                   // [6] power_enable, [8:7] phase,
                                                   // [24:9] measured_mv
);

  localparam int ResW = $bits(svs_pkg::result_t);

  svs_pkg::item_t   conv_item;
  svs_pkg::item_t   in_item;
  logic             in_valid;
  svs_pkg::result_t seq_result;
  svs_pkg::result_t out_result;
  logic             out_valid;
  logic             advance;

  svs_convert u_convert (
    .action     (s_tuser),
    .adc_sample (s_tdata[svs_pkg::AdcW-1:0]),
    .request_mv (s_tdata[svs_pkg::AdcW +: svs_pkg::MvW]),
    .item       (conv_item)
  );

  // Move the held item on when the result register is free
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= conv_item;
    end
  end

  svs_sequencer u_sequencer (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .result (seq_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= seq_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(svs_pkg::OutDataW - ResW){1'b0}}, out_result};

endmodule
